/* rtl/lshc_pkg.sv */
// Shared types, constants and the log-table entry function for the heatmap colorizer.
package lshc_pkg;

  localparam int MaxPixelsDef = 16384;
  localparam int LogTableEntriesDef = 256;
  localparam int WeightW = 24;
  localparam int LogW = 21;
  localparam int CfgW = 15;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusZeroMax = 2'd1;
  localparam logic [1:0] StatusNotReady = 2'd2;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRead = 1'b1;

  typedef struct packed {
    logic load;
    logic read_start;
    logic div_start;
    logic emit_zero;
    logic emit_notready;
  } lshc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero_max;
    logic ready_frame;
  } lshc_stat_t;

  // log2(1 + k/2^b) in Q0.16, by repeated squaring of a Q2.30 mantissa
  function automatic logic [15:0] log_entry(input int k, input int b);
    logic [63:0] m;
    logic [15:0] r;
    m = 64'((64'(1) << b) + 64'(k)) << (30 - b);
    r = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      r = {r[14:0], 1'b0};
      if (m >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/lshc_ctrl.sv */
// Controller state machine for the heatmap colorizer.
module lshc_ctrl import lshc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      req_type,
  input  logic      out_busy,
  input  lshc_stat_t stat,
  output lshc_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_LOG, S_DIV} state_t;
  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (req_type == ReqLoad) begin
            cmd.load = 1'b1;
          end else if (!stat.ready_frame) begin
            cmd.emit_notready = 1'b1;
          end else if (stat.zero_max) begin
            cmd.emit_zero = 1'b1;
          end else begin
            cmd.read_start = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_LOG;
      S_LOG: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: if (stat.div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* rtl/lshc_datapath.sv */
// Datapath: weight memory, counters, log unit, divider, color map and output register.
module lshc_datapath import lshc_pkg::*; #(
  parameter int MAX_PIXELS = MaxPixelsDef,
  parameter int LOG_TABLE_ENTRIES = LogTableEntriesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CfgW-1:0]   cfg_wr_data,
  input  logic [WeightW-1:0] weight,
  input  lshc_cmd_t          cmd,
  output lshc_stat_t         stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int TB = $clog2(LOG_TABLE_ENTRIES + 1) - 1;
  localparam int IW = 21;

  logic [WeightW-1:0] mem [MAX_PIXELS];
  logic [WeightW-1:0] rd_q_r;
  logic [CfgW-1:0] fp_r;
  logic [IW-1:0] n_eff;
  logic [IW-1:0] load_idx_r, read_idx_r;
  logic [WeightW-1:0] max_w_r;
  logic [LogW-1:0] max_log_r;
  logic frame_ready_r;
  logic last_hold_r;
  logic [15:0] log_tab [2**TB];

  // constant log table, folded at elaboration
  for (genvar k = 0; k < 2**TB; k++) begin : g_tab
    assign log_tab[k] = log_entry(k, TB);
  end

  always_comb begin
    n_eff = IW'(fp_r);
    if (fp_r == '0) n_eff = IW'(1);
    if (IW'(fp_r) > IW'(MAX_PIXELS)) n_eff = IW'(MAX_PIXELS);
  end

  function automatic logic [LogW-1:0] log_q16(input logic [WeightW-1:0] w);
    logic [WeightW:0] v;
    logic [4:0] p;
    logic [WeightW+TB:0] sh;
    logic [TB-1:0] idx;
    v = {1'b0, w} + 25'd256;
    p = 5'd8;
    for (int i = 9; i <= 24; i++) if (v[i]) p = 5'(i);
    sh = ({{TB{1'b0}}, v} << TB) >> p;
    idx = sh[TB-1:0];
    return LogW'({(p - 5'd8), 16'd0}) + LogW'(log_tab[idx]);
  endfunction

  wire last_now = (read_idx_r + IW'(1)) >= n_eff;
  wire do_emit = cmd.emit_zero || cmd.emit_notready;

  // divider: (lw << 16) / max_log, one quotient bit a cycle
  logic [36:0] num_r;
  logic [LogW:0] rem_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [LogW:0] rem_sh;
  assign rem_sh = {rem_r[LogW-1:0], num_r[36]};
  wire ge = rem_sh >= {1'b0, max_log_r};

  logic [36:0] q;
  logic [15:0] t;
  logic [7:0] s;
  logic [7:0] r8, g8, b8;
  always_comb begin
    q = {num_r[35:0], ge};
    t = (q[36:16] != '0) ? 16'hFFFF : q[15:0];
    s = t[13:6];
    case (t[15:14])
      2'd0: begin r8 = 8'd0; g8 = s; b8 = 8'd255; end
      2'd1: begin r8 = 8'd0; g8 = 8'd255; b8 = 8'd255 - s; end
      2'd2: begin r8 = s; g8 = 8'd255; b8 = 8'd0; end
      default: begin r8 = 8'd255; g8 = 8'd255 - s; b8 = 8'd0; end
    endcase
  end
  wire div_fin = busy_r && (cnt_r == 6'd36);

  always_ff @(posedge clk) begin
    if (cmd.load) mem[load_idx_r[AW-1:0]] <= weight;
    // hold the weight of the pixel being read
    if (cmd.read_start) rd_q_r <= mem[read_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r <= CfgW'(16384);
      load_idx_r <= '0;
      read_idx_r <= '0;
      max_w_r <= '0;
      max_log_r <= '0;
      frame_ready_r <= 1'b0;
      busy_r <= 1'b0;
      cnt_r <= '0;
      out_tvalid <= 1'b0;
      last_hold_r <= 1'b0;
    end else begin
      if (cfg_wr_en) fp_r <= cfg_wr_data;
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (cmd.load) begin
        if ((load_idx_r + IW'(1)) >= n_eff) begin
          max_log_r <= log_q16((weight > max_w_r) ? weight : max_w_r);
          max_w_r <= '0;
          load_idx_r <= '0;
          read_idx_r <= '0;
          frame_ready_r <= 1'b1;
        end else begin
          if (weight > max_w_r) max_w_r <= weight;
          load_idx_r <= load_idx_r + IW'(1);
        end
      end
      if (cmd.read_start || cmd.emit_zero) begin
        last_hold_r <= last_now;
        read_idx_r <= last_now ? '0 : read_idx_r + IW'(1);
      end
      if (do_emit) begin
        out_tvalid <= 1'b1;
        out_tdata <= {6'd0, cmd.emit_zero ? StatusZeroMax : StatusNotReady, 24'd0};
        out_tlast <= cmd.emit_zero ? last_now : 1'b0;
      end
      if (cmd.div_start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        num_r <= {log_q16(rd_q_r), 16'd0};
      end else if (busy_r) begin
        rem_r <= ge ? rem_sh - {1'b0, max_log_r} : rem_sh;
        num_r <= {num_r[35:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (div_fin) begin
          busy_r <= 1'b0;
          out_tvalid <= 1'b1;
          out_tdata <= {6'd0, StatusOk, b8, g8, r8};
          out_tlast <= last_hold_r;
        end
      end
    end
  end

  assign stat.div_done = div_fin;
  assign stat.zero_max = (max_log_r == '0);
  assign stat.ready_frame = frame_ready_r;

endmodule

/* rtl/log_scaled_heatmap_colorizer.sv */
// Top level of the log-scaled false-color heatmap colorizer.
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | in_tuser=req_type, in_tdata=weight
// out_    | out | out_tvalid/out_tready| out_tdata=red,green,blue,status; out_tlast=last_pixel
// cfg_    | in  | cfg_wr_en            | cfg_wr_data=frame_pixels
// A read passes through the memory read, log, then a 37-step radix-2
// divider before its result is valid. Not-ready and zero-max reads have
// their result valid the cycle after acceptance.
// rst_n is synchronous; the weight memory is not cleared.
// A new item is taken only once the previous result has left the output register.
module log_scaled_heatmap_colorizer import lshc_pkg::*; #(
  parameter int MAX_PIXELS = MaxPixelsDef,
  parameter int LOG_TABLE_ENTRIES = LogTableEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // weight
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red, green, blue, status[1:0], zeros
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data
);

  lshc_cmd_t cmd;
  lshc_stat_t stat;

  lshc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .req_type(in_tuser), .out_busy(out_tvalid), .stat(stat), .cmd(cmd)
  );

  lshc_datapath #(.MAX_PIXELS(MAX_PIXELS), .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .weight(in_tdata), .cmd(cmd), .stat(stat), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule
